[rtl/sacc_pkg.sv]
// Shared types, constants and helpers for the servo angle command conditioner.
`default_nettype none

package sacc_pkg;

   localparam int SERVO_COUNT = 4;
   localparam int SERVO_W     = 2;
   localparam int COUNT_W     = 3;

   localparam logic [SERVO_W-1:0] GRIP_INDEX  = SERVO_W'(SERVO_COUNT - 1);
   localparam logic [7:0]         ANGLE_MAX   = 8'd180;
   localparam logic [7:0]         ANGLE_RESET = 8'd90;
   localparam logic [9:0]         RAW_MAX     = 10'd1023;
   localparam logic [15:0]        COUNT_MAX   = 16'hFFFF;

   localparam logic [9:0]  DEADBAND_RESET = 10'd5;
   localparam logic [7:0]  STEP_RESET     = 8'd30;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [7:0]  HOLD_RESET     = 8'd100;
   localparam logic [7:0]  RELEASE_RESET  = 8'd180;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_POT   = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_DEADBAND = 3'd0,
      REG_STEP     = 3'd1,
      REG_DEBOUNCE = 3'd2,
      REG_HOLD     = 3'd3,
      REG_RELEASE  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [9:0]  deadband_raw;
      logic [7:0]  max_angle_step;
      logic [15:0] debounce_ticks;
      logic [7:0]  gripper_hold_angle;
      logic [7:0]  gripper_release_angle;
   } cfg_type;

   typedef struct packed {
      logic               write_valid;
      logic [SERVO_W-1:0] servo_select;
      logic [7:0]         angle;
   } entry_type;

   typedef struct packed {
      logic [COUNT_W-1:0]               count;
      entry_type [SERVO_COUNT-1:0]      entries;
      logic                             mode;
   } burst_type;

   function automatic logic [7:0] sat_angle(input logic [7:0] a);
      return (a > ANGLE_MAX) ? ANGLE_MAX : a;
   endfunction

endpackage

`default_nettype wire

[rtl/servo_angle_command_conditioner.sv]
// Servo angle command conditioner: debounced mode button, pot mapping and remote frames.
//
// Items arrive on the req_ channel (valid/stall) and are taken at any edge where
// req_valid is high and req_stall low. Each item is held in an input register and
// processed in one pass; its results are loaded into a result register and leave on
// the rsp_ channel as beats, the final one flagged by rsp_last_of_run. An accepted item
// waits in the input register until the result register can take it, and the result
// register then presents its first beat. Pot samples, ticks that apply no frame and
// remote frames held as pending give one beat and can be accepted every cycle while
// rsp_stall is low. An applied remote frame, direct or via a tick, gives four beats,
// one per cycle unless rsp_stall is high. While rsp_stall is high the current beat
// holds; once the input register is also full, req_stall rises until the result
// register can take the next item. Configuration is written on the csr_ channel
// (csr_ready is always high); the user must write it only while the block is idle, which
// the block does not enforce. Synchronous reset restores the configuration and state
// registers, mode potentiometer, every servo angle at 90, and empties both channels.
`default_nettype none

module servo_angle_command_conditioner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_button_level,
   input  wire logic [1:0]  req_servo_index,
   input  wire logic [9:0]  req_pot_raw,
   input  wire logic [7:0]  req_remote_angle_a,
   input  wire logic [7:0]  req_remote_angle_b,
   input  wire logic [7:0]  req_remote_angle_c,
   input  wire logic [7:0]  req_remote_grip,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_write_valid,
   output logic [1:0]       rsp_servo_select,
   output logic [7:0]       rsp_angle_out,
   output logic             rsp_mode_out,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   sacc_pkg::cfg_type   cfg;
   sacc_pkg::burst_type burst;
   logic                load;
   logic                can_load;

   sacc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sacc_core u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_button_level   (req_button_level),
      .req_servo_index    (req_servo_index),
      .req_pot_raw        (req_pot_raw),
      .req_remote_angle_a (req_remote_angle_a),
      .req_remote_angle_b (req_remote_angle_b),
      .req_remote_angle_c (req_remote_angle_c),
      .req_remote_grip    (req_remote_grip),
      .cfg                (cfg),
      .can_load           (can_load),
      .load               (load),
      .burst              (burst)
   );

   sacc_burst u_burst (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .burst            (burst),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_servo_select (rsp_servo_select),
      .rsp_angle_out    (rsp_angle_out),
      .rsp_mode_out     (rsp_mode_out),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[rtl/sacc_csr.sv]
// Configuration register file for the servo angle command conditioner.
`default_nettype none

module sacc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_data,
   output sacc_pkg::cfg_type      cfg
);

   sacc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_raw          <= sacc_pkg::DEADBAND_RESET;
         cfg_ff.max_angle_step        <= sacc_pkg::STEP_RESET;
         cfg_ff.debounce_ticks        <= sacc_pkg::DEBOUNCE_RESET;
         cfg_ff.gripper_hold_angle    <= sacc_pkg::HOLD_RESET;
         cfg_ff.gripper_release_angle <= sacc_pkg::RELEASE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (sacc_pkg::reg_index_type'(csr_index))
            sacc_pkg::REG_DEADBAND: cfg_ff.deadband_raw          <= csr_data[9:0];
            sacc_pkg::REG_STEP:     cfg_ff.max_angle_step        <= csr_data[7:0];
            sacc_pkg::REG_DEBOUNCE: cfg_ff.debounce_ticks        <= csr_data;
            sacc_pkg::REG_HOLD:     cfg_ff.gripper_hold_angle    <= csr_data[7:0];
            sacc_pkg::REG_RELEASE:  cfg_ff.gripper_release_angle <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/sacc_core.sv]
// Input register, conditioner state and the single-pass update logic.
`default_nettype none

module sacc_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_action,
   input  wire logic                          req_button_level,
   input  wire logic [1:0]                    req_servo_index,
   input  wire logic [9:0]                    req_pot_raw,
   input  wire logic [7:0]                    req_remote_angle_a,
   input  wire logic [7:0]                    req_remote_angle_b,
   input  wire logic [7:0]                    req_remote_angle_c,
   input  wire logic [7:0]                    req_remote_grip,
   input  wire sacc_pkg::cfg_type             cfg,
   input  wire logic                          can_load,
   output logic                               load,
   output sacc_pkg::burst_type                burst
);

   localparam int N         = sacc_pkg::SERVO_COUNT;
   localparam int W         = sacc_pkg::SERVO_W;
   localparam int COUNT_W_L = sacc_pkg::COUNT_W;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           action_ff;
   logic                 level_ff;
   logic [W-1:0]         index_ff;
   logic [9:0]           raw_ff;
   logic [N-1:0][7:0]    frame_ff;

   // Conditioner state
   logic                 mode_ff, mode_in;
   logic                 prev_ff, prev_in;
   logic                 handled_ff, handled_in;
   logic [15:0]          stable_ff, stable_in;
   logic [N-1:0][7:0]    angles_ff, angles_in;
   logic [N-1:0][9:0]    accepted_ff, accepted_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [N-1:0][7:0]    pend_ff, pend_in;

   logic                 accept;
   logic                 same_level;
   logic [15:0]          stable_tick;
   logic                 handled_tick;
   logic                 press;
   logic [7:0]           hold_angle;
   logic [N-1:0][7:0]    frame_src;
   logic [N-1:0][7:0]    frame_angle;
   logic [9:0]           inv_raw;
   logic [17:0]          scaled;
   logic [7:0]           quot_lo;
   logic [10:0]          rem;
   logic [7:0]           pot_angle;
   logic [9:0]           last_raw;
   logic [9:0]           raw_diff;
   logic [7:0]           cur_angle;
   logic [7:0]           angle_diff;
   logic [COUNT_W_L-1:0] n_results;
   sacc_pkg::entry_type [N-1:0] entries;

   assign load      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Debounce: the count restarts whenever the level changes.
   assign same_level   = (level_ff == prev_ff);
   assign stable_tick  = !same_level ? 16'd0 :
                         (stable_ff != sacc_pkg::COUNT_MAX) ? stable_ff + 16'd1 : stable_ff;
   assign handled_tick = same_level && handled_ff;
   assign press        = (stable_tick > cfg.debounce_ticks) && !level_ff && !handled_tick;

   assign hold_angle = sacc_pkg::sat_angle(cfg.gripper_hold_angle);

   // A frame is applied either from the stored pending copy or straight from the input.
   assign frame_src = (sacc_pkg::action_type'(action_ff) == sacc_pkg::ACT_TICK) ?
                      pend_ff : frame_ff;

   always_comb begin
      for (int i = 0; i < N - 1; i++) begin
         frame_angle[i] = sacc_pkg::sat_angle(frame_src[i]);
      end
      frame_angle[N-1] = (frame_src[N-1] != 8'd0) ? hold_angle :
                         sacc_pkg::sat_angle(cfg.gripper_release_angle);
   end

   // Inverse map: (1023 - raw) * 180 / 1023. Dividing by 1024 instead falls short
   // by at most one, which the remainder compare puts right.
   assign inv_raw   = sacc_pkg::RAW_MAX - raw_ff;
   assign scaled    = 18'(inv_raw) * 18'(sacc_pkg::ANGLE_MAX);
   assign quot_lo   = scaled[17:10];
   assign rem       = 11'(scaled[9:0]) + 11'(quot_lo);
   assign pot_angle = (rem >= 11'(sacc_pkg::RAW_MAX)) ? quot_lo + 8'd1 : quot_lo;

   assign last_raw   = accepted_ff[index_ff];
   assign raw_diff   = (raw_ff > last_raw) ? raw_ff - last_raw : last_raw - raw_ff;
   assign cur_angle  = angles_ff[index_ff];
   assign angle_diff = (pot_angle > cur_angle) ? pot_angle - cur_angle : cur_angle - pot_angle;

   always_comb begin
      mode_in       = mode_ff;
      prev_in       = prev_ff;
      handled_in    = handled_ff;
      stable_in     = stable_ff;
      angles_in     = angles_ff;
      accepted_in   = accepted_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      entries       = '0;
      n_results     = '0;

      unique case (sacc_pkg::action_type'(action_ff))
         sacc_pkg::ACT_TICK: begin
            stable_in  = stable_tick;
            handled_in = handled_tick || press;
            prev_in    = level_ff;
            if (press) begin
               mode_in = !mode_ff;
               if (mode_ff) begin
                  angles_in[sacc_pkg::GRIP_INDEX] = hold_angle;
                  entries[0] = '{1'b1, sacc_pkg::GRIP_INDEX, hold_angle};
                  n_results  = COUNT_W_L'(1);
               end else if (pend_valid_ff) begin
                  pend_valid_in = 1'b0;
                  angles_in     = frame_angle;
                  for (int i = 0; i < N; i++) begin
                     entries[i] = '{1'b1, W'(i), frame_angle[i]};
                  end
                  n_results = COUNT_W_L'(N);
               end
            end
         end
         sacc_pkg::ACT_POT: begin
            if (!mode_ff && (raw_diff > cfg.deadband_raw) &&
                (angle_diff <= cfg.max_angle_step)) begin
               accepted_in[index_ff] = raw_ff;
               angles_in[index_ff]   = pot_angle;
               entries[0] = '{1'b1, index_ff, pot_angle};
               n_results  = COUNT_W_L'(1);
            end
         end
         sacc_pkg::ACT_FRAME: begin
            if (mode_ff) begin
               angles_in = frame_angle;
               for (int i = 0; i < N; i++) begin
                  entries[i] = '{1'b1, W'(i), frame_angle[i]};
               end
               n_results = COUNT_W_L'(N);
            end else begin
               pend_in       = frame_ff;
               pend_valid_in = 1'b1;
            end
         end
         sacc_pkg::ACT_NONE: begin
         end
      endcase
   end

   // An input that commands nothing still yields one idle beat.
   assign burst.count   = (n_results == '0) ? COUNT_W_L'(1) : n_results;
   assign burst.entries = entries;
   assign burst.mode    = mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_action;
         level_ff    <= req_button_level;
         index_ff    <= req_servo_index;
         raw_ff      <= req_pot_raw;
         frame_ff[0] <= req_remote_angle_a;
         frame_ff[1] <= req_remote_angle_b;
         frame_ff[2] <= req_remote_angle_c;
         frame_ff[3] <= req_remote_grip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         prev_ff       <= 1'b1;
         handled_ff    <= 1'b0;
         stable_ff     <= 16'd0;
         angles_ff     <= {N{sacc_pkg::ANGLE_RESET}};
         accepted_ff   <= '0;
         pend_valid_ff <= 1'b0;
         pend_ff       <= '0;
      end else if (load) begin
         mode_ff       <= mode_in;
         prev_ff       <= prev_in;
         handled_ff    <= handled_in;
         stable_ff     <= stable_in;
         angles_ff     <= angles_in;
         accepted_ff   <= accepted_in;
         pend_valid_ff <= pend_valid_in;
         pend_ff       <= pend_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sacc_burst.sv]
// Result register that holds one input's results and sends them one beat per cycle while rsp_stall is low.
`default_nettype none

module sacc_burst (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire sacc_pkg::burst_type    burst,
   output logic                        can_load,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_write_valid,
   output logic [1:0]                  rsp_servo_select,
   output logic [7:0]                  rsp_angle_out,
   output logic                        rsp_mode_out,
   output logic                        rsp_last_of_run
);

   localparam int N  = sacc_pkg::SERVO_COUNT;
   localparam int CW = sacc_pkg::COUNT_W;
   localparam int PW = sacc_pkg::SERVO_W;

   logic [CW-1:0]               remaining_ff, remaining_in;
   logic [PW-1:0]               ptr_ff, ptr_in;
   sacc_pkg::entry_type [N-1:0] entries_ff;
   logic                        mode_ff;
   logic                        take;
   sacc_pkg::entry_type         head;

   assign take     = (remaining_ff != '0) && !rsp_stall;
   // A new burst may follow straight on from the last beat of the one in flight.
   assign can_load = (remaining_ff == '0) || ((remaining_ff == CW'(1)) && !rsp_stall);

   always_comb begin
      if (load) begin
         remaining_in = burst.count;
         ptr_in       = '0;
      end else if (take) begin
         remaining_in = remaining_ff - CW'(1);
         ptr_in       = ptr_ff + PW'(1);
      end else begin
         remaining_in = remaining_ff;
         ptr_in       = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         ptr_ff       <= '0;
      end else begin
         remaining_ff <= remaining_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= burst.entries;
         mode_ff    <= burst.mode;
      end
   end

   assign head             = entries_ff[ptr_ff];
   assign rsp_valid        = (remaining_ff != '0);
   assign rsp_write_valid  = head.write_valid;
   assign rsp_servo_select = head.servo_select;
   assign rsp_angle_out    = head.angle;
   assign rsp_mode_out     = mode_ff;
   assign rsp_last_of_run  = (remaining_ff == CW'(1));

endmodule

`default_nettype wire
